// ===== src/ipf_pkg.sv =====
// Shared constants, codes and a helper function for the IPv4 prefix packet filter.
// Depends on nothing; the filter top level refers to it by scoped names.

package ipf_pkg;

  // Default table sizes.
  localparam int SOURCE_RULES_DEFAULT      = 32;
  localparam int DESTINATION_RULES_DEFAULT = 32;

  // Field widths of the request and result items.
  localparam int KIND_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int SLOT_W      = 5;
  localparam int ADDR_W      = 32;
  localparam int PLEN_W      = 6;
  localparam int VERDICT_W   = 2;
  localparam int COUNT_W     = 32;
  localparam int POS_W       = 6;
  localparam int ETYPE_W     = 16;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_FIELDS_W  = BYTE_W + SLOT_W + ADDR_W + PLEN_W + 1;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = VERDICT_W + 3 * COUNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_FRAME_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SRC_RULE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DST_RULE   = 2'd2;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_ABORTED  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DROP     = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_PASS     = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_TRANSMIT = 2'd3;

  // Header layout.
  localparam logic [ETYPE_W-1:0] ETHER_TYPE_IPV4 = 16'h0800;
  localparam logic [POS_W-1:0]   ETH_HEADER_BYTES = 6'd14;
  localparam logic [POS_W-1:0]   IPV4_MIN_BYTES   = 6'd34;
  localparam logic [POS_W-1:0]   POSITION_LIMIT   = 6'd34;
  localparam logic [POS_W-1:0]   ETYPE_FIRST      = 6'd12;
  localparam logic [POS_W-1:0]   ETYPE_LAST       = 6'd13;
  localparam logic [POS_W-1:0]   SRC_FIRST        = 6'd26;
  localparam logic [POS_W-1:0]   SRC_LAST         = 6'd29;
  localparam logic [POS_W-1:0]   DST_FIRST        = 6'd30;
  localparam logic [POS_W-1:0]   DST_LAST         = 6'd33;
  localparam logic [PLEN_W-1:0]  FULL_PREFIX      = 6'd32;

  // Network mask for a prefix length; lengths above 32 give a full mask.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
    logic [PLEN_W-1:0] sat;
    logic [PLEN_W-1:0] shift;
    sat   = (len > FULL_PREFIX) ? FULL_PREFIX : len;
    shift = FULL_PREFIX - sat;
    if (sat == '0) begin
      prefix_mask = '0;
    end else begin
      prefix_mask = {ADDR_W{1'b1}} << shift;
    end
  endfunction

endpackage

// ===== src/ipv4_prefix_packet_filter.sv =====
// Top level of the IPv4 prefix packet filter: byte parser, rule tables and verdict counters.
// Depends on ipf_pkg for widths, codes and the prefix mask function.
//
//   Channel   Direction  Handshake                      Payload (lowest bits first)
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata: byte, slot, address, length,
//                                                       valid; tuser: kind; tlast: last byte
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata: verdict, pass, drop, transmit
//
// A request is first captured in the input register. The stage behind it is combinational and
// loads the output register, so a verdict passes both registers once the request with the last
// frame byte is accepted. One request is accepted per cycle unless a result stalls, and at frame
// end all source and destination rules are compared in parallel; other requests give no result.
// Reset clears the frame parser, every rule valid bit and the three counters at once.
// A stalled result holds the output register and the request behind it, whatever its kind;
// s_axis_tready drops in the same cycle unless the input register is still empty.

module ipv4_prefix_packet_filter #(
  parameter int SOURCE_RULES      = ipf_pkg::SOURCE_RULES_DEFAULT,
  parameter int DESTINATION_RULES = ipf_pkg::DESTINATION_RULES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: frame_byte[7:0], rule_slot[12:8], rule_address[44:13],
  //        rule_prefix_length[50:45], rule_valid[51], zero pad[55:52]
  input  logic [ipf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [ipf_pkg::KIND_W-1:0]      s_axis_tuser,
  input  logic                            s_axis_tlast,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: verdict[1:0], pass_total[33:2], drop_total[65:34],
  //        transmit_total[97:66], zero pad[103:98]
  output logic [ipf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);

  localparam int AW = ipf_pkg::ADDR_W;
  localparam int CW = ipf_pkg::COUNT_W;

  // ------------------------------------------------------------------
  // Input register. Payload is captured without reset; only the valid
  // flag is control state.
  // ------------------------------------------------------------------
  logic                           in_valid;
  logic [ipf_pkg::KIND_W-1:0]     in_kind;
  logic [ipf_pkg::BYTE_W-1:0]     in_byte;
  logic                           in_last;
  logic [ipf_pkg::SLOT_W-1:0]     in_slot;
  logic [AW-1:0]                  in_addr;
  logic [ipf_pkg::PLEN_W-1:0]     in_plen;
  logic                           in_rvalid;

  logic advance;      // the processing stage consumes the request in the input register
  logic produce;      // that request yields a verdict

  // The stage can move whenever the output register is empty or being emptied.
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind   <= s_axis_tuser;
      in_byte   <= s_axis_tdata[7:0];
      in_last   <= s_axis_tlast;
      in_slot   <= s_axis_tdata[12:8];
      in_addr   <= s_axis_tdata[44:13];
      in_plen   <= s_axis_tdata[50:45];
      in_rvalid <= s_axis_tdata[51];
    end
  end

  // ------------------------------------------------------------------
  // Frame parser state: position within the frame and captured header.
  // ------------------------------------------------------------------
  logic [ipf_pkg::POS_W-1:0]   byte_position, byte_position_next;
  logic [ipf_pkg::ETYPE_W-1:0] ether_type, ether_type_next;
  logic [AW-1:0]               source_address, source_address_next;
  logic [AW-1:0]               destination_address, destination_address_next;

  logic is_frame_byte;
  assign is_frame_byte = (in_kind == ipf_pkg::KIND_FRAME_BYTE);
  assign produce       = is_frame_byte && in_last;

  // Header fields as they stand once the current byte is taken in.
  always_comb begin
    ether_type_next          = ether_type;
    source_address_next      = source_address;
    destination_address_next = destination_address;
    if (byte_position == ipf_pkg::ETYPE_FIRST || byte_position == ipf_pkg::ETYPE_LAST) begin
      ether_type_next = {ether_type[7:0], in_byte};
    end else if (byte_position >= ipf_pkg::SRC_FIRST && byte_position <= ipf_pkg::SRC_LAST) begin
      source_address_next = {source_address[AW-9:0], in_byte};
    end else if (byte_position >= ipf_pkg::DST_FIRST && byte_position <= ipf_pkg::DST_LAST) begin
      destination_address_next = {destination_address[AW-9:0], in_byte};
    end
    // Long frames just sit at the limit.
    if (byte_position < ipf_pkg::POSITION_LIMIT) begin
      byte_position_next = byte_position + ipf_pkg::POS_W'(1);
    end else begin
      byte_position_next = byte_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      ether_type          <= '0;
      source_address      <= '0;
      destination_address <= '0;
    end else if (advance && is_frame_byte) begin
      if (in_last) begin
        // The frame is done: start the next one from a clean header.
        byte_position       <= '0;
        ether_type          <= '0;
        source_address      <= '0;
        destination_address <= '0;
      end else begin
        byte_position       <= byte_position_next;
        ether_type          <= ether_type_next;
        source_address      <= source_address_next;
        destination_address <= destination_address_next;
      end
    end
  end

  // ------------------------------------------------------------------
  // Rule tables. Each entry is its own register with a valid bit, and
  // each is compared in parallel against the captured address. Source
  // rules keep the expanded mask rather than the prefix length.
  // ------------------------------------------------------------------
  logic [SOURCE_RULES-1:0]      src_match;
  logic [DESTINATION_RULES-1:0] dst_match;

  logic src_write, dst_write;
  assign src_write = advance && (in_kind == ipf_pkg::KIND_SRC_RULE);
  assign dst_write = advance && (in_kind == ipf_pkg::KIND_DST_RULE);

  for (genvar i = 0; i < SOURCE_RULES; i++) begin : g_src
    localparam logic [7:0] SLOT_ID = 8'(i);
    logic          enabled;
    logic [AW-1:0] rule_addr;
    logic [AW-1:0] rule_mask;
    logic          hit_slot;

    // Slots beyond the table never match and are thereby ignored.
    assign hit_slot = ({3'b000, in_slot} == SLOT_ID);

    always_ff @(posedge clk) begin
      if (rst) begin
        enabled <= 1'b0;
      end else if (src_write && hit_slot) begin
        enabled <= in_rvalid;
      end
    end

    always_ff @(posedge clk) begin
      if (src_write && hit_slot) begin
        rule_addr <= in_addr;
        rule_mask <= ipf_pkg::prefix_mask(in_plen);
      end
    end

    assign src_match[i] = enabled && (((source_address_next ^ rule_addr) & rule_mask) == '0);
  end

  for (genvar j = 0; j < DESTINATION_RULES; j++) begin : g_dst
    localparam logic [7:0] SLOT_ID = 8'(j);
    logic          enabled;
    logic [AW-1:0] rule_addr;
    logic          hit_slot;

    assign hit_slot = ({3'b000, in_slot} == SLOT_ID);

    always_ff @(posedge clk) begin
      if (rst) begin
        enabled <= 1'b0;
      end else if (dst_write && hit_slot) begin
        enabled <= in_rvalid;
      end
    end

    always_ff @(posedge clk) begin
      if (dst_write && hit_slot) begin
        rule_addr <= in_addr;
      end
    end

    assign dst_match[j] = enabled && (destination_address_next == rule_addr);
  end

  // ------------------------------------------------------------------
  // Verdict and counters.
  // ------------------------------------------------------------------
  logic [ipf_pkg::VERDICT_W-1:0] verdict_next;
  logic [CW-1:0] pass_count, drop_count, transmit_count;
  logic [CW-1:0] pass_count_next, drop_count_next, transmit_count_next;

  // byte_position_next is the frame length here, saturated at the limit.
  always_comb begin
    pass_count_next     = pass_count;
    drop_count_next     = drop_count;
    transmit_count_next = transmit_count;
    if (byte_position_next < ipf_pkg::ETH_HEADER_BYTES) begin
      verdict_next = ipf_pkg::VERDICT_ABORTED;
    end else if (ether_type_next != ipf_pkg::ETHER_TYPE_IPV4) begin
      verdict_next    = ipf_pkg::VERDICT_PASS;
      pass_count_next = pass_count + CW'(1);
    end else if (byte_position_next < ipf_pkg::IPV4_MIN_BYTES) begin
      verdict_next = ipf_pkg::VERDICT_ABORTED;
    end else if ((|src_match) || (|dst_match)) begin
      verdict_next        = ipf_pkg::VERDICT_TRANSMIT;
      transmit_count_next = transmit_count + CW'(1);
    end else begin
      verdict_next    = ipf_pkg::VERDICT_DROP;
      drop_count_next = drop_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count     <= '0;
      drop_count     <= '0;
      transmit_count <= '0;
    end else if (advance && produce) begin
      pass_count     <= pass_count_next;
      drop_count     <= drop_count_next;
      transmit_count <= transmit_count_next;
    end
  end

  // ------------------------------------------------------------------
  // Output register.
  // ------------------------------------------------------------------
  logic                          out_valid;
  logic [ipf_pkg::VERDICT_W-1:0] out_verdict;
  logic [CW-1:0]                 out_pass, out_drop, out_transmit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= produce;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      out_verdict  <= verdict_next;
      out_pass     <= pass_count_next;
      out_drop     <= drop_count_next;
      out_transmit <= transmit_count_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(ipf_pkg::OUT_DATA_W - ipf_pkg::OUT_FIELDS_W)'(0),
                          out_transmit, out_drop, out_pass, out_verdict};

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_result_follows_stage: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_valid == $past(produce)))
    else $error("output valid does not match the request that left the stage");

  a_abort_keeps_counts: assert property (@(posedge clk) disable iff (rst)
    (advance && produce && verdict_next == ipf_pkg::VERDICT_ABORTED) |=>
      ($stable(pass_count) && $stable(drop_count) && $stable(transmit_count)))
    else $error("an aborted frame changed a counter");

  a_position_saturates: assert property (@(posedge clk) disable iff (rst)
    byte_position <= ipf_pkg::POSITION_LIMIT)
    else $error("byte position ran past its limit");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && produce) |=> (byte_position == '0 && ether_type == '0))
    else $error("parser state not cleared after the last byte");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("empty input register refuses a request");

endmodule
